// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst_n, expr, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;
    localparam int KEY_W = 20;
    localparam int HANDLE_W = 16;
    localparam int SEQ_W = 32;
    localparam int OCC_W = 7;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic                command;
        logic [KEY_W-1:0]    priority_key;
        logic [HANDLE_W-1:0] payload_handle;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_W-1:0]    out_key;
        logic [HANDLE_W-1:0] out_handle;
        logic [SEQ_W-1:0]    out_sequence;
        logic [OCC_W-1:0]    occupancy;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic push;
        logic pop_empty;
        logic pop_start;
        logic scan;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic empty;
        logic scan_last;
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/spq_ram.sv -----
`default_nettype none
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/spq_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"
module spq_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spq_pkg::t_cmd i_cmd,
    input  wire spq_pkg::t_in  i_in,
    output spq_pkg::t_stat     o_stat,
    output spq_pkg::t_out      o_result
);
    import spq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    logic [CW-1:0]    r_count, n_count;
    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [AW-1:0]    r_idx, n_idx;
    t_entry           r_best, n_best;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    t_out             r_out, n_out;

    logic [SEQ_W-1:0] seq_eff;
    logic             full;
    logic             exhausted;
    logic             push_ok;
    logic             better;
    logic             pop_done;
    logic             we;
    logic [AW-1:0]    waddr;
    t_entry           wdata;
    t_entry           rd_entry;
    logic [EW-1:0]    rdata;

    spq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(n_idx),
        .o_rdata(rdata)
    );

    always_comb begin
        rd_entry = t_entry'(rdata);
        // A push into an empty queue restarts the sequence numbering.
        seq_eff = (r_count == '0) ? '0 : r_next_seq;
        full = (r_count >= CW'(QUEUE_DEPTH));
        exhausted = (seq_eff == {SEQ_W{1'b1}});
        push_ok = i_cmd.push && !full && !exhausted;
        o_stat.empty = (r_count == '0);
        o_stat.scan_last = ((CW'(r_idx) + CW'(1)) == r_count);
        pop_done = i_cmd.scan && o_stat.scan_last;

        better = (rd_entry.key > r_best.key)
            || ((rd_entry.key == r_best.key) && (rd_entry.seq < r_best.seq));

        n_count = r_count;
        n_next_seq = r_next_seq;
        n_idx = r_idx + AW'(1);
        n_best = r_best;
        n_best_idx = r_best_idx;
        n_out = r_out;
        we = 1'b0;
        waddr = AW'(r_count);
        wdata = '{key: i_in.priority_key, seq: seq_eff, handle: i_in.payload_handle};

        if (i_cmd.pop_start) begin
            n_idx = '0;
        end

        if (i_cmd.scan) begin
            if (r_idx == '0 || better) begin
                n_best = rd_entry;
                n_best_idx = r_idx;
            end
        end

        if (i_cmd.push) begin
            n_out = '{status: ST_OK, out_key: '0, out_handle: '0,
                      out_sequence: '0, occupancy: OCC_W'(r_count)};
            if (full) begin
                n_out.status = ST_FULL;
            end else if (exhausted) begin
                n_out.status = ST_EXHAUSTED;
            end else begin
                we = 1'b1;
                n_count = r_count + CW'(1);
                n_next_seq = seq_eff + SEQ_W'(1);
                n_out.out_sequence = seq_eff;
                n_out.occupancy = OCC_W'(n_count);
            end
        end

        if (i_cmd.pop_empty) begin
            n_out = '{status: ST_EMPTY, out_key: '0, out_handle: '0,
                      out_sequence: '0, occupancy: OCC_W'(r_count)};
        end

        // Last entry read: the winner leaves and the last slot fills its hole.
        if (pop_done) begin
            we = 1'b1;
            waddr = n_best_idx;
            wdata = rd_entry;
            n_count = r_count - CW'(1);
            n_out = '{status: ST_OK, out_key: n_best.key, out_handle: n_best.handle,
                      out_sequence: n_best.seq, occupancy: OCC_W'(n_count)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next_seq <= '0;
        end else begin
            r_count <= n_count;
            r_next_seq <= n_next_seq;
        end
        r_idx <= n_idx;
        r_best <= n_best;
        r_best_idx <= n_best_idx;
        r_out <= n_out;
    end

    assign o_result = r_out;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH),
        "occupancy above queue depth")
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push_ok,
        r_count == $past(r_count) + CW'(1), "accepted push did not add an entry")
    `SPQ_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, pop_done,
        r_count == $past(r_count) - CW'(1), "finished pop did not remove an entry")
endmodule
`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module spq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_command,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd       o_cmd
);
    import spq_pkg::*;

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    always_comb begin
        o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        accept = i_in_valid && o_in_ready;
        o_cmd.push = accept && (i_in_command == CMD_PUSH);
        o_cmd.pop_empty = accept && (i_in_command == CMD_POP) && i_stat.empty;
        o_cmd.pop_start = accept && (i_in_command == CMD_POP) && !i_stat.empty;
        o_cmd.scan = (r_state == S_SCAN);

        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.pop_start) begin
                    n_state = S_SCAN;
                end
                if (o_cmd.push || o_cmd.pop_empty) begin
                    n_out_valid = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SPQ_ASSERT(a_scan_slot_free, i_clk, i_rst_n, !(r_state == S_SCAN && r_out_valid),
        "result register occupied during a scan")
    `SPQ_ASSERT_NEXT(a_pop_scans, i_clk, i_rst_n, o_cmd.pop_start, r_state == S_SCAN,
        "pop did not start a scan")
    `SPQ_ASSERT_NEXT(a_push_result, i_clk, i_rst_n, o_cmd.push, r_out_valid,
        "push gave no result")
endmodule
`default_nettype wire

// ----- rtl/stable_max_priority_queue_unit.sv -----
`default_nettype none
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in_data  (spq_pkg::t_in)
// out       output     o_out_valid / i_out_ready   o_out_data (spq_pkg::t_out)
//
// A push, or a pop on an empty queue, is answered straight from the idle state. A
// pop on a queue holding entries scans all of them first: the entry memory has
// one read port, and the search for the winner reads one entry a cycle.
// Reset is synchronous and active low; it empties the queue and clears the
// sequence counter, while the entry memory itself is never cleared.
// A new transaction is taken while the previous result waits only when the
// result is taken in the same cycle; a stalled output holds the input off.
module stable_max_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire spq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spq_pkg::t_out      o_out_data
);
    import spq_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    // The sequencer owns the handshakes and decides when a pop scan runs.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_command(i_in_data.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the entries, the counters, the running winner of a
    // scan and the result register.
    spq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_stat  (stat),
        .o_result(o_out_data)
    );
endmodule
`default_nettype wire

// ----- dv/stable_max_priority_queue_unit_test.sv -----
`default_nettype none
module stable_max_priority_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = '1;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out_data;

    stable_max_priority_queue_unit #(.QUEUE_DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the queue contents, kept in the same slot order as the block's
    // memory would be, although the slot order never decides which entry is served.
    logic [KEY_W-1:0]    shadow_keys [DEPTH];
    logic [SEQ_W-1:0]    shadow_seqs [DEPTH];
    logic [HANDLE_W-1:0] shadow_handles [DEPTH];
    int unsigned         shadow_count = 0;
    logic [SEQ_W-1:0]    shadow_next_seq = '0;

    // Results still owed by the block, oldest first.
    t_out pending_results[$];
    int   error_count = 0;
    // When set, the sender runs flat out with no gaps at all.
    bit   burst_mode = 1'b0;
    // Set by the drain phase so that the receiver takes every result at once.
    bit   sink_eager = 1'b0;
    // Cycles left in a long receiver stall.
    int unsigned stall_left = 0;

    // Works out the result of one accepted transaction and updates the shadow queue.
    function automatic t_out apply_operation(t_in op);
        t_out        res;
        int unsigned best;
        int unsigned last;
        res = '0;
        if (op.command == CMD_PUSH) begin
            if (shadow_count == 0)
                shadow_next_seq = '0;
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else if (shadow_next_seq == SEQ_ALL_ONES) begin
                res.status = ST_EXHAUSTED;
            end else begin
                shadow_keys[shadow_count]    = op.priority_key;
                shadow_seqs[shadow_count]    = shadow_next_seq;
                shadow_handles[shadow_count] = op.payload_handle;
                shadow_count++;
                res.status       = ST_OK;
                res.out_sequence = shadow_next_seq;
                shadow_next_seq  = shadow_next_seq + 1'b1;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // Largest key wins; on a tie the older entry, with the lower
                // sequence number, is served first.
                best = 0;
                for (int unsigned i = 1; i < shadow_count; i++) begin
                    if (shadow_keys[i] > shadow_keys[best] ||
                        (shadow_keys[i] == shadow_keys[best] &&
                         shadow_seqs[i] < shadow_seqs[best]))
                        best = i;
                end
                res.status       = ST_OK;
                res.out_key      = shadow_keys[best];
                res.out_handle   = shadow_handles[best];
                res.out_sequence = shadow_seqs[best];
                last = shadow_count - 1;
                shadow_keys[best]    = shadow_keys[last];
                shadow_seqs[best]    = shadow_seqs[last];
                shadow_handles[best] = shadow_handles[last];
                shadow_count = last;
            end
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // Offers one transaction and returns once it has been accepted. Valid is kept high
    // from one transaction to the next when there is no gap, so it is never lowered
    // and raised again within one time step.
    task automatic send_operation(t_in op);
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.insert(pending_results.size(), apply_operation(op));
    endtask

    task automatic push_entry(logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
        t_in op;
        op.command        = CMD_PUSH;
        op.priority_key   = key;
        op.payload_handle = handle;
        send_operation(op);
    endtask

    task automatic pop_entry();
        t_in op;
        op.command        = CMD_POP;
        op.priority_key   = KEY_W'($urandom());
        op.payload_handle = HANDLE_W'($urandom());
        send_operation(op);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // The receiver stalls at random, with long stalls now and then, except while
    // draining, when it takes everything at once.
    always @(posedge i_clk) begin
        int unsigned r;
        r = $urandom_range(99);
        if (sink_eager) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (r < 3) begin
            stall_left = $urandom_range(40, 10);
            i_out_ready <= 1'b0;
        end else if (r < 8)
            i_out_ready <= 1'b0;
        else if (r < 30)
            i_out_ready <= 1'($urandom_range(1));
        else
            i_out_ready <= 1'b1;
    end

    // Every result transaction is compared with the oldest owed result.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with none outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.out_key !== want.out_key) begin
                    $error("out_key: expected %0d, got %0d",
                           want.out_key, o_out_data.out_key);
                    error_count++;
                end
                if (o_out_data.out_handle !== want.out_handle) begin
                    $error("out_handle: expected %0d, got %0d",
                           want.out_handle, o_out_data.out_handle);
                    error_count++;
                end
                if (o_out_data.out_sequence !== want.out_sequence) begin
                    $error("out_sequence: expected %0d, got %0d",
                           want.out_sequence, o_out_data.out_sequence);
                    error_count++;
                end
                if (o_out_data.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_out_data.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Popping an empty queue straight after reset, then a push that must be stamped
    // with sequence zero, and the field extremes.
    task automatic test_empty_queue();
        pop_entry();
        pop_entry();
        push_entry('1, '1);
        push_entry('0, '0);
        pop_entry();
        pop_entry();
        pop_entry();
    endtask

    // Equal keys must leave in arrival order; a push that finds the queue empty
    // restarts the sequence counter.
    task automatic test_tie_order();
        push_entry(20'd5, 16'hAAAA);
        push_entry(20'd9, 16'h0001);
        push_entry(20'd5, 16'h5555);
        push_entry(20'd5, 16'h1234);
        push_entry(20'd9, 16'h0002);
        repeat (5) pop_entry();
        push_entry(20'd7, 16'h00FF);
        pop_entry();
    endtask

    // Fill to capacity, try two pushes too many, then empty it completely and pop once more.
    task automatic test_full_queue();
        burst_mode = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            push_entry(KEY_W'($urandom_range(3)), HANDLE_W'($urandom()));
        burst_mode = 1'b0;
        push_entry('1, '1);
        push_entry(KEY_W'($urandom()), HANDLE_W'($urandom()));
        for (int i = 0; i < DEPTH + 1; i++)
            pop_entry();
    endtask

    // Random traffic that swings the fill level between empty and full, with keys
    // drawn from a narrow range most of the time so that ties are frequent.
    task automatic test_random_traffic(int unsigned count);
        int unsigned push_bias;
        logic [KEY_W-1:0] key;
        push_bias = 70;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                push_bias = $urandom_range(85, 15);
                burst_mode = ($urandom_range(3) == 0);
            end
            if (n == count / 2) begin
                burst_mode = 1'b0;
                wait_for_drain();
            end
            if ($urandom_range(99) < push_bias) begin
                key = ($urandom_range(3) == 0) ? KEY_W'($urandom())
                                               : KEY_W'($urandom_range(7));
                push_entry(key, HANDLE_W'($urandom()));
            end else begin
                pop_entry();
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        int unsigned settle;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_tie_order();
        test_full_queue();
        test_random_traffic(350);

        i_in_valid <= 1'b0;
        sink_eager = 1'b1;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // A pop scans every entry in the queue, so wait long enough for a scan of a full queue.
        settle = 0;
        while (settle < 2 * DEPTH + 20) begin
            @(posedge i_clk);
            settle++;
        end
        if (error_count == 0 && pending_results.size() == 0)
            $display("stable_max_priority_queue_unit verification clean");
        else
            $display("stable_max_priority_queue_unit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("stable_max_priority_queue_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
